/* hdl/rtpro_pkg.sv */
`timescale 1ns / 1ps
// Shared types, codes and helpers for the RTP sequence reorder buffer.
// No dependencies; imported by rtpro_cfg, rtpro_scan, the top level and the bench.
package rtpro_pkg;

  localparam logic [15:0] SEQ_UNKNOWN = 16'hFFFF;

  localparam logic        MODE_ADD = 1'b0;
  localparam logic        MODE_GET = 1'b1;

  // register index, taken from paddr[2]
  localparam logic        REG_MAX_SIZE  = 1'b0;
  localparam logic        REG_MAX_QTIME = 1'b1;

  localparam logic [4:0]  MAX_SIZE_RST  = 5'd16;
  localparam logic [15:0] MAX_QTIME_RST = 16'd40;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SCAN,
    ST_SDRAIN,
    ST_DECIDE,
    ST_SHIFT,
    ST_SHDRAIN
  } state_e;

  typedef struct packed {
    logic clr;
    logic vld;
  } scan_ctl_t;

  // a is before b in serial (wrapping) order
  function automatic logic seq_before(input logic [15:0] a, input logic [15:0] b);
    logic [15:0] diff;
    diff = a - b;
    return diff[15];
  endfunction

endpackage

/* hdl/rtpro_cfg.sv */
`timescale 1ns / 1ps
// APB register file: max_size and max_queue_time.
// Depends on rtpro_pkg.
module rtpro_cfg
  import rtpro_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [4:0]  max_size_o,
  output logic [15:0] max_qtime_o
);

  logic [4:0]  msz_q, msz_d;
  logic [15:0] mqt_q, mqt_d;
  logic        wr_en;

  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;

  always_comb begin
    msz_d = msz_q;
    mqt_d = mqt_q;
    if (wr_en) begin
      case (paddr[2])
        REG_MAX_SIZE:  msz_d = pwdata[4:0];
        REG_MAX_QTIME: mqt_d = pwdata[15:0];
        default:       msz_d = msz_q;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_MAX_SIZE:  prdata = {27'd0, msz_q};
      REG_MAX_QTIME: prdata = {16'd0, mqt_q};
      default:       prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      msz_q <= MAX_SIZE_RST;
      mqt_q <= MAX_QTIME_RST;
    end else begin
      msz_q <= msz_d;
      mqt_q <= mqt_d;
    end
  end

  assign max_size_o  = msz_q;
  assign max_qtime_o = mqt_q;

endmodule

/* hdl/rtpro_mem.sv */
`timescale 1ns / 1ps
// Entry memory: one write port, one read port, registered read data.
// No package dependency.
module rtpro_mem #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 56
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/rtpro_scan.sv */
`timescale 1ns / 1ps
// Scan accumulator: first match on a target sequence, serially lowest
// sequence and smallest time over the entries streamed in. Uses rtpro_pkg.
module rtpro_scan
  import rtpro_pkg::*;
#(
  parameter int AW = 4,
  parameter int TW = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  scan_ctl_t     ctl_i,
  input  logic [AW-1:0] idx_i,
  input  logic [15:0]   seq_i,
  input  logic [7:0]    hdl_i,
  input  logic [TW-1:0] time_i,
  input  logic [15:0]   target_i,
  output logic          hit_o,
  output logic [AW-1:0] hit_idx_o,
  output logic [7:0]    hit_hdl_o,
  output logic [15:0]   low_seq_o,
  output logic [TW-1:0] min_time_o
);

  logic          hit_q, hit_d;
  logic [AW-1:0] hidx_q, hidx_d;
  logic [7:0]    hhdl_q, hhdl_d;
  logic [15:0]   low_q, low_d;
  logic [TW-1:0] min_q, min_d;
  logic          first;

  assign first = (idx_i == '0);

  always_comb begin
    hit_d  = hit_q;
    hidx_d = hidx_q;
    hhdl_d = hhdl_q;
    low_d  = low_q;
    min_d  = min_q;
    if (ctl_i.clr) begin
      hit_d = 1'b0;
    end else if (ctl_i.vld) begin
      if (!hit_q && seq_i == target_i) begin
        hit_d  = 1'b1;
        hidx_d = idx_i;
        hhdl_d = hdl_i;
      end
      if (first || seq_before(seq_i, low_q)) begin
        low_d = seq_i;
      end
      if (first || time_i < min_q) begin
        min_d = time_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
    end else begin
      hit_q <= hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hidx_q <= hidx_d;
    hhdl_q <= hhdl_d;
    low_q  <= low_d;
    min_q  <= min_d;
  end

  assign hit_o      = hit_q;
  assign hit_idx_o  = hidx_q;
  assign hit_hdl_o  = hhdl_q;
  assign low_seq_o  = low_q;
  assign min_time_o = min_q;

endmodule

/* hdl/rtp_sequence_reorder_buffer.sv */
`timescale 1ns / 1ps
// RTP sequence reorder buffer, top level.
// Depends on rtpro_pkg, rtpro_cfg, rtpro_mem and rtpro_scan.
//
// Usage:
//   Command channel: raise start with mode/seq/packet_handle/now_ms; the word
//   is taken at a clock edge with start high and busy low. mode 0 adds a
//   packet, mode 1 gets the next in-order queued packet.
//   Result channel: done_o pulses for one cycle with the status word
//   (handle_now, consumed, ready_res for an add; found, out_handle, out_seq
//   for a get). The receiver cannot stall; every result is taken on its pulse.
//   Config: APB port, max_size at byte 0, max_queue_time at byte 4; write
//   only while busy is low.
// Operation, with N entries queued:
//   An add that is rejected early, or any word that meets an empty table,
//   finishes in the check state. Otherwise the table is scanned through the
//   single memory read port, one entry per cycle. A get that removes entry k
//   also compacts the table by copying entries k+1..N-1 down one slot per
//   cycle, unless k is the last entry.
// Reset: table empty, expected sequence unknown, oldest time unknown,
//   registers at max_size 16 and max_queue_time 40. No clearing pass.
module rtp_sequence_reorder_buffer
  import rtpro_pkg::*;
#(
  parameter int CAPACITY  = 16,
  parameter int TIME_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // command channel
  input  logic        start,
  output logic        busy,
  input  logic        mode_i,
  input  logic [15:0] seq_i,
  input  logic [7:0]  packet_handle_i,
  input  logic [31:0] now_ms_i,
  // result channel
  output logic        done_o,
  output logic        handle_now_o,
  output logic        consumed_o,
  output logic        ready_res_o,
  output logic        found_o,
  output logic [7:0]  out_handle_o,
  output logic [15:0] out_seq_o,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int AW   = $clog2(CAPACITY);
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW > 5) ? CW : 5;
  localparam int TW   = TIME_BITS;
  localparam int EW   = 24 + TW;

  // config
  logic [4:0]  max_size;
  logic [15:0] max_qtime;

  // control state
  state_e        state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [15:0]   exp_q, exp_d;
  logic [TW-1:0] old_q, old_d;
  logic          okn_q, okn_d;
  logic [AW-1:0] ptr_q, ptr_d;
  logic          dvld_q;
  logic [AW-1:0] didx_q;
  logic          done_q, done_d;

  // latched command word
  logic          mode_q;
  logic [15:0]   seq_q;
  logic [7:0]    hdl_q;
  logic [31:0]   now_q;

  // result word
  logic          hn_q, hn_d, cons_q, cons_d, rdy_q, rdy_d, fnd_q, fnd_d;
  logic [7:0]    ohdl_q, ohdl_d;
  logic [15:0]   oseq_q, oseq_d;

  // memory port
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [EW-1:0] mem_wdata, mem_rdata;
  logic [15:0]   rd_seq;
  logic [7:0]    rd_hdl;
  logic [TW-1:0] rd_time;

  // scan results
  scan_ctl_t     scan_ctl;
  logic          hit;
  logic [AW-1:0] hit_idx;
  logic [7:0]    hit_hdl;
  logic [15:0]   low_seq;
  logic [TW-1:0] min_time;

  // decision terms
  logic [63:0]   now_w, mqt_w;
  logic [TW-1:0] now_t;
  logic          accept, is_add, early_rej, empty, chk_fin, dec_fin;
  logic          ptr_last, hit_last, fire, can_store, behind_new;
  logic [15:0]   exp_new;
  logic [CMPW-1:0] cnt_x, msz_x;

  assign accept  = start & ~busy;
  assign busy    = (state_q != ST_IDLE);
  assign is_add  = (mode_q == MODE_ADD);
  assign empty   = (cnt_q == '0);
  assign now_w   = {32'd0, now_q};
  assign now_t   = now_w[TW-1:0];
  assign mqt_w   = {48'd0, max_qtime};
  assign cnt_x   = CMPW'(cnt_q);
  assign msz_x   = CMPW'(max_size);

  assign early_rej = (exp_q != SEQ_UNKNOWN) && seq_before(seq_q, exp_q);
  assign chk_fin   = is_add ? (early_rej || empty) : empty;
  assign ptr_last  = (CW'(ptr_q) == cnt_q - CW'(1));
  assign hit_last  = (CW'(hit_idx) == cnt_q - CW'(1));

  // constraints force expected to the lowest queued sequence
  assign fire = (okn_q && ((now_t - old_q) > mqt_w[TW-1:0])) ||
                ((max_size != 5'd0) && (cnt_x == msz_x - CMPW'(1)));
  assign exp_new    = fire ? low_seq : exp_q;
  assign behind_new = fire && (exp_new != SEQ_UNKNOWN) && seq_before(seq_q, exp_new);
  assign can_store  = !hit && (cnt_q < CW'(CAPACITY));
  assign dec_fin    = is_add || !hit || hit_last;

  assign rd_seq  = mem_rdata[EW-1 -: 16];
  assign rd_hdl  = mem_rdata[TW +: 8];
  assign rd_time = mem_rdata[TW-1:0];

  assign scan_ctl.clr = (state_q == ST_CHECK);
  assign scan_ctl.vld = dvld_q && ((state_q == ST_SCAN) || (state_q == ST_SDRAIN));

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:    if (accept) state_d = ST_CHECK;
      ST_CHECK:   state_d = chk_fin ? ST_IDLE : ST_SCAN;
      ST_SCAN:    if (ptr_last) state_d = ST_SDRAIN;
      ST_SDRAIN:  state_d = ST_DECIDE;
      ST_DECIDE:  state_d = dec_fin ? ST_IDLE : ST_SHIFT;
      ST_SHIFT:   if (ptr_last) state_d = ST_SHDRAIN;
      ST_SHDRAIN: state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    cnt_d     = cnt_q;
    exp_d     = exp_q;
    old_d     = old_q;
    okn_d     = okn_q;
    ptr_d     = ptr_q;
    done_d    = 1'b0;
    hn_d      = hn_q;
    cons_d    = cons_q;
    rdy_d     = rdy_q;
    fnd_d     = fnd_q;
    ohdl_d    = ohdl_q;
    oseq_d    = oseq_q;
    mem_we    = 1'b0;
    mem_waddr = cnt_q[AW-1:0];
    mem_wdata = {seq_q, hdl_q, now_t};
    mem_re    = 1'b0;
    mem_raddr = ptr_q;
    case (state_q)
      ST_CHECK: begin
        ptr_d = '0;
        if (chk_fin) begin
          done_d = 1'b1;
          {hn_d, cons_d, rdy_d, fnd_d} = 4'b0000;
          ohdl_d = 8'd0;
          oseq_d = 16'd0;
          if (is_add && !early_rej) begin
            if (exp_q == SEQ_UNKNOWN || seq_q == exp_q) begin
              exp_d = seq_q + 16'd1;
              hn_d  = 1'b1;
            end else begin
              // empty table: store at slot zero
              mem_we    = 1'b1;
              mem_waddr = '0;
              cnt_d     = CW'(1);
              cons_d    = 1'b1;
              if (!okn_q) begin
                old_d = now_t;
                okn_d = 1'b1;
              end
            end
          end else if (!is_add) begin
            okn_d = 1'b0;
          end
        end
      end
      ST_SCAN: begin
        mem_re = 1'b1;
        ptr_d  = ptr_q + AW'(1);
      end
      ST_DECIDE: begin
        {hn_d, cons_d, rdy_d, fnd_d} = 4'b0000;
        ohdl_d = 8'd0;
        oseq_d = 16'd0;
        done_d = dec_fin;
        if (is_add) begin
          exp_d = exp_new;
          if (behind_new) begin
            rdy_d = 1'b1;
          end else if (can_store) begin
            mem_we = 1'b1;
            cnt_d  = cnt_q + CW'(1);
            cons_d = 1'b1;
            rdy_d  = fire || (seq_q == exp_new);
            if (!okn_q) begin
              old_d = now_t;
              okn_d = 1'b1;
            end
          end
        end else if (hit) begin
          fnd_d  = 1'b1;
          ohdl_d = hit_hdl;
          oseq_d = exp_q;
          exp_d  = exp_q + 16'd1;
          ptr_d  = hit_idx + AW'(1);
          if (hit_last) begin
            cnt_d = cnt_q - CW'(1);
          end
        end else begin
          old_d = min_time;
          okn_d = 1'b1;
        end
      end
      ST_SHIFT: begin
        mem_re = 1'b1;
        ptr_d  = ptr_q + AW'(1);
      end
      ST_SHDRAIN: begin
        cnt_d  = cnt_q - CW'(1);
        done_d = 1'b1;
      end
      default: begin
        ptr_d = ptr_q;
      end
    endcase
    // compaction: copy each entry read back down one slot
    if (dvld_q && ((state_q == ST_SHIFT) || (state_q == ST_SHDRAIN))) begin
      mem_we    = 1'b1;
      mem_waddr = didx_q - AW'(1);
      mem_wdata = mem_rdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      exp_q   <= SEQ_UNKNOWN;
      old_q   <= '0;
      okn_q   <= 1'b0;
      ptr_q   <= '0;
      dvld_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      exp_q   <= exp_d;
      old_q   <= old_d;
      okn_q   <= okn_d;
      ptr_q   <= ptr_d;
      dvld_q  <= mem_re;
      done_q  <= done_d;
    end
  end

  // payload registers: hold the command word, track the read address
  always_ff @(posedge clk_i) begin
    didx_q <= mem_raddr;
    if (accept) begin
      mode_q <= mode_i;
      seq_q  <= seq_i;
      hdl_q  <= packet_handle_i;
      now_q  <= now_ms_i;
    end
    hn_q   <= hn_d;
    cons_q <= cons_d;
    rdy_q  <= rdy_d;
    fnd_q  <= fnd_d;
    ohdl_q <= ohdl_d;
    oseq_q <= oseq_d;
  end

  assign done_o       = done_q;
  assign handle_now_o = hn_q;
  assign consumed_o   = cons_q;
  assign ready_res_o  = rdy_q;
  assign found_o      = fnd_q;
  assign out_handle_o = ohdl_q;
  assign out_seq_o    = oseq_q;

  rtpro_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .max_size_o  (max_size),
    .max_qtime_o (max_qtime)
  );

  rtpro_mem #(
    .DEPTH (CAPACITY),
    .WIDTH (EW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  rtpro_scan #(
    .AW (AW),
    .TW (TW)
  ) u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (scan_ctl),
    .idx_i      (didx_q),
    .seq_i      (rd_seq),
    .hdl_i      (rd_hdl),
    .time_i     (rd_time),
    .target_i   (is_add ? seq_q : exp_q),
    .hit_o      (hit),
    .hit_idx_o  (hit_idx),
    .hit_hdl_o  (hit_hdl),
    .low_seq_o  (low_seq),
    .min_time_o (min_time)
  );

  // table never holds more than its capacity
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(CAPACITY))
    else $error("entry count above capacity");

  // a result is only presented once the sequencer is back at rest
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while busy");

  // add status and get status never mix in one result
  a_status_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && found_o |-> !handle_now_o && !consumed_o && !ready_res_o)
    else $error("get result carries add status");

  // in-order packet is never also stored
  a_hn_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && handle_now_o |-> !consumed_o && !ready_res_o)
    else $error("handle_now with consumed or ready");

  // an accepted word always occupies the block on the next cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy && !done_o)
    else $error("accepted word did not start processing");

endmodule

/* bench/rtp_sequence_reorder_buffer_test.sv */
`timescale 1ns / 1ps
// Self-checking bench for rtp_sequence_reorder_buffer: directed and random add/get words
// with a word-level predictor in a small scoreboard class. Depends on rtpro_pkg and the RTL.
module rtp_sequence_reorder_buffer_test
  import rtpro_pkg::*;
();

  localparam int CAP = 16;
  localparam int CYCLE_LIMIT = 600000;
  // registers sit at byte addresses 0 and 4; the index lands on paddr[2]
  localparam logic [2:0] ADDR_MAX_SIZE  = {REG_MAX_SIZE, 2'b00};
  localparam logic [2:0] ADDR_MAX_QTIME = {REG_MAX_QTIME, 2'b00};

  // one result word as the block presents it
  typedef struct packed {
    logic        handle_now;
    logic        consumed;
    logic        ready_res;
    logic        found;
    logic [7:0]  handle;
    logic [15:0] seq;
  } outcome_t;

  // Holds its own copy of the reorder table and registers, predicts the result of every
  // accepted word and checks results against the oldest prediction.
  class reorder_tracker;
    logic [15:0] q_seq[CAP];
    logic [7:0]  q_handle[CAP];
    logic [31:0] q_time[CAP];
    int          q_count;
    logic [15:0] next_seq;
    logic [31:0] oldest_ms;
    bit          oldest_valid;
    logic [4:0]  size_limit;
    logic [15:0] wait_limit;
    outcome_t    due_results[$];
    int          errors;

    function new();
      q_count      = 0;
      next_seq     = SEQ_UNKNOWN;
      oldest_ms    = '0;
      oldest_valid = 1'b0;
      size_limit   = MAX_SIZE_RST;
      wait_limit   = MAX_QTIME_RST;
      errors       = 0;
    endfunction

    function void fault(string msg);
      errors++;
      if (errors <= 10) $display("mismatch: %s", msg);
    endfunction

    function string show(outcome_t o);
      return $sformatf("hn=%0b cons=%0b rdy=%0b found=%0b handle=%02h seq=%04h",
                       o.handle_now, o.consumed, o.ready_res, o.found, o.handle, o.seq);
    endfunction

    // serial order: a is before b when the wrapped difference has its top bit set
    function bit precedes(logic [15:0] a, logic [15:0] b);
      logic [15:0] d;
      d = a - b;
      return d[15];
    endfunction

    // append to the table unless the number is already queued or the table is full
    function bit stash(logic [15:0] s, logic [7:0] h, logic [31:0] t);
      for (int i = 0; i < q_count; i++)
        if (q_seq[i] == s) return 1'b0;
      if (q_count >= CAP) return 1'b0;
      q_seq[q_count]    = s;
      q_handle[q_count] = h;
      q_time[q_count]   = t;
      if (!oldest_valid) begin
        oldest_ms    = t;
        oldest_valid = 1'b1;
      end
      q_count++;
      return 1'b1;
    endfunction

    // timeout or size bound: jump the expected number to the lowest queued one
    function bit force_release(logic [31:0] t);
      bit          fire;
      int          low;
      logic [31:0] age;
      if (q_count == 0) return 1'b0;
      age  = t - oldest_ms;
      fire = oldest_valid && (age > 32'(wait_limit));
      if (!fire && size_limit != 0 && q_count == int'(size_limit) - 1) fire = 1'b1;
      if (!fire) return 1'b0;
      low = 0;
      for (int i = 1; i < q_count; i++)
        if (precedes(q_seq[i], q_seq[low])) low = i;
      next_seq = q_seq[low];
      return 1'b1;
    endfunction

    function outcome_t predict_add(logic [15:0] s, logic [7:0] h, logic [31:0] t);
      outcome_t r;
      bit       lowest;
      r = '0;
      if (next_seq != SEQ_UNKNOWN && precedes(s, next_seq)) return r;
      if (q_count == 0) begin
        if (next_seq == SEQ_UNKNOWN || s == next_seq) begin
          next_seq     = s + 16'd1;
          r.handle_now = 1'b1;
          return r;
        end
        r.consumed = stash(s, h, t);
        return r;
      end
      lowest = force_release(t);
      if (lowest && next_seq != SEQ_UNKNOWN && precedes(s, next_seq)) begin
        r.ready_res = 1'b1;
        return r;
      end
      if (s == next_seq) begin
        if (stash(s, h, t)) begin
          r.consumed  = 1'b1;
          r.ready_res = 1'b1;
        end
        return r;
      end
      if (!stash(s, h, t)) return r;
      r.consumed  = 1'b1;
      r.ready_res = lowest;
      return r;
    endfunction

    function outcome_t predict_get();
      outcome_t r;
      r = '0;
      for (int i = 0; i < q_count; i++) begin
        if (q_seq[i] == next_seq) begin
          r.found  = 1'b1;
          r.handle = q_handle[i];
          r.seq    = q_seq[i];
          next_seq = next_seq + 16'd1;
          // compact the table, keeping arrival order
          for (int j = i; j + 1 < q_count; j++) begin
            q_seq[j]    = q_seq[j + 1];
            q_handle[j] = q_handle[j + 1];
            q_time[j]   = q_time[j + 1];
          end
          q_count--;
          return r;
        end
      end
      // nothing matched: recompute the oldest time by plain unsigned compare
      if (q_count == 0) begin
        oldest_valid = 1'b0;
      end else begin
        oldest_ms = q_time[0];
        for (int i = 1; i < q_count; i++)
          if (q_time[i] < oldest_ms) oldest_ms = q_time[i];
        oldest_valid = 1'b1;
      end
      return r;
    endfunction

    function void note_word(logic m, logic [15:0] s, logic [7:0] h, logic [31:0] t);
      if (m == MODE_GET) due_results.push_back(predict_get());
      else due_results.push_back(predict_add(s, h, t));
    endfunction

    function void check_word(outcome_t got);
      outcome_t want;
      if (due_results.size() == 0) begin
        fault($sformatf("unexpected result %s", show(got)));
        return;
      end
      want = due_results.pop_front();
      if (got !== want)
        fault($sformatf("expected %s, got %s", show(want), show(got)));
    endfunction

    function void check_reg(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want)
        fault($sformatf("%s readback expected %08h, got %08h", name, want, got));
    endfunction
  endclass

  logic        clk_i   = 1'b0;
  logic        rst_ni  = 1'b0;
  logic        start   = 1'b0;
  logic        busy;
  logic        mode_i  = MODE_ADD;
  logic [15:0] seq_i   = '0;
  logic [7:0]  packet_handle_i = '0;
  logic [31:0] now_ms_i = '0;
  logic        done_o;
  logic        handle_now_o;
  logic        consumed_o;
  logic        ready_res_o;
  logic        found_o;
  logic [7:0]  out_handle_o;
  logic [15:0] out_seq_o;
  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [2:0]  paddr   = '0;
  logic [31:0] pwdata  = '0;
  logic [31:0] prdata;
  logic        pready;

  reorder_tracker sb = new();
  int          cycles = 0;
  logic [31:0] wall_ms = '0;

  rtp_sequence_reorder_buffer #(
    .CAPACITY (CAP),
    .TIME_BITS(32)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .mode_i         (mode_i),
    .seq_i          (seq_i),
    .packet_handle_i(packet_handle_i),
    .now_ms_i       (now_ms_i),
    .done_o         (done_o),
    .handle_now_o   (handle_now_o),
    .consumed_o     (consumed_o),
    .ready_res_o    (ready_res_o),
    .found_o        (found_o),
    .out_handle_o   (out_handle_o),
    .out_seq_o      (out_seq_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Watch the result strobe and the cycle budget. Outputs are read at the edge, before
  // the block's own updates land, so every sample is the value of the cycle just ended.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("rtp_sequence_reorder_buffer_test: FAIL");
      $finish;
    end
    if (rst_ni && done_o === 1'b1)
      sb.check_word({handle_now_o, consumed_o, ready_res_o, found_o, out_handle_o, out_seq_o});
  end

  // Present a word and hold it until the block takes it (start high, busy low at an edge).
  // Leave start high on return so that the next word can follow back to back.
  task automatic send_word(logic m, logic [15:0] s, logic [7:0] h, logic [31:0] t);
    start           <= 1'b1;
    mode_i          <= m;
    seq_i           <= s;
    packet_handle_i <= h;
    now_ms_i        <= t;
    do @(posedge clk_i); while (busy !== 1'b0);
    sb.note_word(m, s, h, t);
  endtask

  // One APB transfer: setup, access until pready, then a return to idle so that a following
  // transfer never re-raises psel in the step that lowered it.
  task automatic apb_xfer(input bit wr, input logic [2:0] addr, input logic [31:0] wdata,
                          output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic check_regs();
    logic [31:0] rd;
    apb_xfer(1'b0, ADDR_MAX_SIZE, '0, rd);
    sb.check_reg("max_size", rd, {27'b0, sb.size_limit});
    apb_xfer(1'b0, ADDR_MAX_QTIME, '0, rd);
    sb.check_reg("max_queue_time", rd, {16'b0, sb.wait_limit});
  endtask

  // Write both registers with junk in the unused upper bits, which the block must drop.
  task automatic program_regs(logic [4:0] size, logic [15:0] qtime);
    logic [31:0] unused;
    apb_xfer(1'b1, ADDR_MAX_SIZE, {27'($urandom), size}, unused);
    sb.size_limit = size;
    apb_xfer(1'b1, ADDR_MAX_QTIME, {16'($urandom), qtime}, unused);
    sb.wait_limit = qtime;
    check_regs();
  endtask

  // Hold off until every predicted word has come back and the block is idle.
  task automatic drain();
    while (sb.due_results.size() != 0 || busy !== 1'b0) @(posedge clk_i);
  endtask

  // Walk the special cases at reset settings: empty get, in-order add, behind, duplicate,
  // out-of-order fill and release, timeout jumps across the wrap and onto the sentinel,
  // a get against the sentinel, and an add that lands behind a forced expected number.
  task automatic directed();
    send_word(MODE_GET, 16'h0000, 8'h00, 32'h0000_0000);
    send_word(MODE_ADD, 16'd100, 8'h00, 32'hFFFF_FFF0);
    send_word(MODE_ADD, 16'd99, 8'hFF, 32'hFFFF_FFFF);
    send_word(MODE_ADD, 16'd103, 8'hA5, 32'hFFFF_FFF2);
    send_word(MODE_ADD, 16'd103, 8'h5A, 32'h0000_0004);
    send_word(MODE_ADD, 16'd102, 8'h01, 32'h0000_0005);
    send_word(MODE_ADD, 16'd101, 8'hFE, 32'h0000_0006);
    repeat (4) send_word(MODE_GET, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF);
    send_word(MODE_ADD, 16'd104, 8'h3C, 32'h0000_0010);
    send_word(MODE_ADD, 16'h7000, 8'h11, 32'h0000_0100);
    send_word(MODE_ADD, 16'hE000, 8'h22, 32'h0000_0200);
    repeat (2) send_word(MODE_GET, 16'h0000, 8'h00, 32'h0000_0000);
    send_word(MODE_ADD, 16'hFFFE, 8'h33, 32'h0000_0300);
    repeat (2) send_word(MODE_GET, 16'h0000, 8'h00, 32'h0000_0000);
    send_word(MODE_ADD, 16'h1000, 8'h44, 32'h0000_0400);
    // this get lands the expected number on the sentinel; the next one compares it as is
    repeat (2) send_word(MODE_GET, 16'h0000, 8'h00, 32'h0000_0000);
    send_word(MODE_ADD, 16'h0005, 8'h55, 32'h0000_0401);
    send_word(MODE_ADD, 16'h0003, 8'h66, 32'h0000_1000);
    send_word(MODE_GET, 16'h0000, 8'h00, 32'h0000_0000);
    send_word(MODE_ADD, 16'hFFFF, 8'hFF, 32'h0000_1001);
    start <= 1'b0;
  endtask

  // One random phase: reprogram while idle, then mostly well-formed traffic around the
  // expected number (in order, slightly ahead, duplicates, late) with some pure noise.
  task automatic run_phase(logic [4:0] size, logic [15:0] qtime, int n, int get_pct,
                           int window, int tstep, bit bursty);
    int          r;
    int          burst;
    logic [15:0] s;
    drain();
    program_regs(size, qtime);
    wall_ms = $urandom;
    burst = $urandom_range(1, 30);
    for (int k = 0; k < n; k++) begin
      wall_ms = wall_ms + 32'($urandom_range(0, tstep));
      // now and then jump the clock anywhere, backward included
      if ($urandom_range(0, 49) == 0) wall_ms = $urandom;
      r = $urandom_range(0, 99);
      if (r < get_pct) begin
        send_word(MODE_GET, 16'($urandom), 8'($urandom), $urandom);
      end else begin
        r = $urandom_range(0, 99);
        if (sb.next_seq == SEQ_UNKNOWN || r < 6) s = 16'($urandom);
        else if (r < 14) s = sb.next_seq - 16'($urandom_range(1, 40));
        else if (r < 22 && sb.q_count > 0) s = sb.q_seq[$urandom_range(0, sb.q_count - 1)];
        else if (r < 35) s = sb.next_seq;
        else s = sb.next_seq + 16'($urandom_range(1, window));
        send_word(MODE_ADD, s, 8'($urandom_range(0, 255)), wall_ms);
      end
      if (k == n - 1) begin
        start <= 1'b0;
      end else if (bursty) begin
        burst--;
        if (burst == 0) begin
          start <= 1'b0;
          repeat ($urandom_range(1, 40)) @(posedge clk_i);
          burst = $urandom_range(1, 30);
        end
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    check_regs();
    directed();
    run_phase(5'd2, 16'd0, 195, 35, 6, 3, 1'b1);
    run_phase(5'd16, 16'hFFFF, 195, 30, 20, 5, 1'b0);
    // size bound off and a long wait: let the table fill up
    run_phase(5'd0, 16'hFFFF, 195, 15, 40, 2, 1'b1);
    run_phase(5'd31, 16'd100, 195, 25, 24, 20, 1'b1);
    run_phase(5'd1, 16'd5, 195, 35, 8, 4, 1'b0);
    run_phase(5'd17, 16'hFFFF, 195, 20, 30, 3, 1'b1);
    run_phase(5'($urandom_range(2, 16)), 16'($urandom_range(0, 200)), 195, 30, 16, 10, 1'b1);
    run_phase(MAX_SIZE_RST, MAX_QTIME_RST, 195, 30, 12, 8, 1'b1);
    drain();
    repeat (2 * CAP + 8) @(posedge clk_i);
    if (sb.errors == 0 && sb.due_results.size() == 0)
      $display("rtp_sequence_reorder_buffer_test: PASS");
    else
      $display("rtp_sequence_reorder_buffer_test: FAIL");
    $finish;
  end

endmodule

/* filelist.f */
hdl/rtpro_pkg.sv
hdl/rtpro_cfg.sv
hdl/rtpro_mem.sv
hdl/rtpro_scan.sv
hdl/rtp_sequence_reorder_buffer.sv
bench/rtp_sequence_reorder_buffer_test.sv
